>>> sv/acs_pkg.sv
// ----------------------------------------------------------------------------
// acs_pkg
// Types and constants shared by the accumulator CPU step unit.
// ----------------------------------------------------------------------------
package acs_pkg;

    localparam int unsigned WORD_W = 16;
    localparam int unsigned ADDR_W = 8;

    // Word that reads back from an unwritten or out-of-range location (halt).
    localparam logic [WORD_W-1:0] RESET_WORD = 16'h0800;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_SET_PC = 2'd1,
        ACT_EXEC   = 2'd2
    } t_action;

    localparam logic [7:0] OP_LOAD   = 8'd0;
    localparam logic [7:0] OP_STORE  = 8'd1;
    localparam logic [7:0] OP_ADD    = 8'd2;
    localparam logic [7:0] OP_SUB    = 8'd3;
    localparam logic [7:0] OP_COPY_B = 8'd4;
    localparam logic [7:0] OP_JUMP   = 8'd5;
    localparam logic [7:0] OP_JUMP_N = 8'd6;
    localparam logic [7:0] OP_OUTPUT = 8'd7;

    typedef struct packed {
        logic [ADDR_W-1:0] pc;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic              neg;
        logic              run;
    } t_cpu_state;

    typedef struct packed {
        t_cpu_state        st;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic              shown;
        logic [ADDR_W-1:0] show_addr;
        logic [WORD_W-1:0] show_val;
        logic              need_opd;
    } t_exec_res;

endpackage

>>> sv/acs_ram.sv
// ----------------------------------------------------------------------------
// acs_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module acs_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

>>> sv/acs_exec.sv
// ----------------------------------------------------------------------------
// acs_exec
// Decode and execute one item against the current processor state.
// ----------------------------------------------------------------------------
module acs_exec (
    input  logic [1:0]           i_action,
    input  logic [7:0]           i_address,
    input  logic [15:0]          i_data,
    input  acs_pkg::t_cpu_state  i_state,
    input  logic [15:0]          i_fetch,
    input  logic [15:0]          i_operand,
    output acs_pkg::t_exec_res   o_res
);

    logic [7:0]  opcode;
    logic [7:0]  opd;
    logic [7:0]  pc_inc;
    logic [15:0] sum;
    logic [15:0] diff;

    assign opcode = i_fetch[15:8];
    assign opd    = i_fetch[7:0];
    assign pc_inc = i_state.pc + 8'd1;
    assign sum    = i_state.a + i_state.b;
    assign diff   = i_state.a - i_state.b;

    always_comb begin
        o_res           = '0;
        o_res.st        = i_state;
        o_res.waddr     = i_address;
        o_res.wdata     = i_data;
        o_res.need_opd  = 1'b0;
        unique case (acs_pkg::t_action'(i_action))
            acs_pkg::ACT_WRITE: begin
                o_res.we = 1'b1;
            end
            acs_pkg::ACT_SET_PC: begin
                o_res.st.pc = i_address;
            end
            acs_pkg::ACT_EXEC: begin
                if (i_state.run) begin
                    unique case (opcode)
                        acs_pkg::OP_LOAD: begin
                            o_res.need_opd = 1'b1;
                            o_res.st.a     = i_operand;
                            o_res.st.neg   = i_operand[15];
                            o_res.st.pc    = pc_inc;
                        end
                        acs_pkg::OP_STORE: begin
                            o_res.we    = 1'b1;
                            o_res.waddr = opd;
                            o_res.wdata = i_state.a;
                            o_res.st.pc = pc_inc;
                        end
                        acs_pkg::OP_ADD: begin
                            o_res.st.a   = sum;
                            o_res.st.neg = sum[15];
                            o_res.st.pc  = pc_inc;
                        end
                        acs_pkg::OP_SUB: begin
                            o_res.st.a   = diff;
                            o_res.st.neg = diff[15];
                            o_res.st.pc  = pc_inc;
                        end
                        acs_pkg::OP_COPY_B: begin
                            o_res.st.b  = i_state.a;
                            o_res.st.pc = pc_inc;
                        end
                        acs_pkg::OP_JUMP: begin
                            o_res.st.pc = opd;
                        end
                        acs_pkg::OP_JUMP_N: begin
                            o_res.st.pc = i_state.neg ? opd : pc_inc;
                        end
                        acs_pkg::OP_OUTPUT: begin
                            o_res.need_opd  = 1'b1;
                            o_res.shown     = 1'b1;
                            o_res.show_addr = opd;
                            o_res.show_val  = i_operand;
                            o_res.st.pc     = pc_inc;
                        end
                        default: begin
                            // halt: pc stays on the halt word
                            o_res.st.run = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

endmodule

>>> sv/accumulator_cpu_step_unit.sv
// ----------------------------------------------------------------------------
// accumulator_cpu_step_unit
// Accumulator processor that takes one command per transfer and reports state.
// ----------------------------------------------------------------------------
// Each accepted item is registered, then executed, and its result lands in an
// output register; a new item is taken every cycle while the output register
// is free to take a result. Load and output instructions hold off the next
// item until their operand word, which comes through the second registered
// read port of the program memory, has arrived; the
// instruction word at the program counter is prefetched through the first
// port, with bypass of a write to the same address. Memory locations not yet
// written since reset read as the halt word 0x0800 through a per-word valid
// bit, so no clearing pass is needed after reset.
module accumulator_cpu_step_unit #(
    parameter int unsigned MEM_WORDS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_action,
    input  logic [7:0]         i_address,
    input  logic signed [15:0] i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_program_counter,
    output logic signed [15:0] o_accumulator,
    output logic               o_negative,
    output logic               o_running,
    output logic               o_out_valid,
    output logic [7:0]         o_out_address,
    output logic signed [15:0] o_out_value
);

    localparam int unsigned AW = $clog2(MEM_WORDS);

    // input stage
    logic        r_in_vld;
    logic [1:0]  r_action;
    logic [7:0]  r_address;
    logic [15:0] r_data;

    acs_pkg::t_cpu_state r_state;
    acs_pkg::t_exec_res  res;

    logic [MEM_WORDS-1:0] r_valid;
    logic                 r_fetch_fwd;
    logic [15:0]          r_fetch_fwd_data;
    logic                 r_fetch_ok;
    logic                 r_opd_ok;
    logic                 r_opd_rdy;

    logic [15:0] ram_q_a;
    logic [15:0] ram_q_b;
    logic [15:0] fetch_word;
    logic [15:0] opd_word;
    logic [7:0]  opd_addr;
    logic [7:0]  n_pc;

    logic complete;
    logic out_free;
    logic accept;
    logic mem_we;
    logic pc_in_range;
    logic opd_in_range;
    logic wr_in_range;

    // output register
    logic        r_out_vld;
    logic [7:0]  r_pc_out;
    logic [15:0] r_a_out;
    logic        r_neg_out;
    logic        r_run_out;
    logic        r_shown;
    logic [7:0]  r_show_addr;
    logic [15:0] r_show_val;

    assign fetch_word = r_fetch_fwd ? r_fetch_fwd_data
                      : (r_fetch_ok ? ram_q_a : acs_pkg::RESET_WORD);
    assign opd_word   = r_opd_ok ? ram_q_b : acs_pkg::RESET_WORD;
    assign opd_addr   = fetch_word[7:0];

    acs_exec u_exec (
        .i_action  (r_action),
        .i_address (r_address),
        .i_data    (r_data),
        .i_state   (r_state),
        .i_fetch   (fetch_word),
        .i_operand (opd_word),
        .o_res     (res)
    );

    assign out_free = !r_out_vld || i_ready;
    assign complete = r_in_vld && out_free && (!res.need_opd || r_opd_rdy);
    assign o_ready  = !r_in_vld || complete;
    assign accept   = i_valid && o_ready;

    assign n_pc         = complete ? res.st.pc : r_state.pc;
    assign pc_in_range  = {1'b0, n_pc} < 9'(MEM_WORDS);
    assign opd_in_range = {1'b0, opd_addr} < 9'(MEM_WORDS);
    assign wr_in_range  = {1'b0, res.waddr} < 9'(MEM_WORDS);
    assign mem_we       = complete && res.we && wr_in_range;

    acs_ram #(
        .WIDTH (16),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (res.waddr[AW-1:0]),
        .i_wdata   (res.wdata),
        .i_raddr_a (n_pc[AW-1:0]),
        .o_rdata_a (ram_q_a),
        .i_raddr_b (opd_addr[AW-1:0]),
        .o_rdata_b (ram_q_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_opd_rdy   <= 1'b0;
            r_valid     <= '0;
            r_fetch_fwd <= 1'b0;
            r_fetch_ok  <= 1'b0;
            r_opd_ok    <= 1'b0;
            r_state     <= '{pc: 8'd0, a: 16'd0, b: 16'd0, neg: 1'b0, run: 1'b1};
        end else begin
            if (accept) begin
                r_in_vld <= 1'b1;
            end else if (complete) begin
                r_in_vld <= 1'b0;
            end

            if (complete) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end

            // hold the operand-ready mark until the item leaves
            if (complete) begin
                r_opd_rdy <= 1'b0;
            end else if (r_in_vld && res.need_opd) begin
                r_opd_rdy <= 1'b1;
            end

            if (mem_we) begin
                r_valid[res.waddr[AW-1:0]] <= 1'b1;
            end

            // bypass a write that lands on the address being prefetched
            r_fetch_fwd <= mem_we && (res.waddr == n_pc);
            r_fetch_ok  <= pc_in_range && r_valid[n_pc[AW-1:0]];
            r_opd_ok    <= opd_in_range && r_valid[opd_addr[AW-1:0]];

            if (complete) begin
                r_state <= res.st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action  <= i_action;
            r_address <= i_address;
            r_data    <= i_data;
        end
        r_fetch_fwd_data <= res.wdata;
        if (complete) begin
            r_pc_out    <= res.st.pc;
            r_a_out     <= res.st.a;
            r_neg_out   <= res.st.neg;
            r_run_out   <= res.st.run;
            r_shown     <= res.shown;
            r_show_addr <= res.show_addr;
            r_show_val  <= res.show_val;
        end
    end

    assign o_valid           = r_out_vld;
    assign o_program_counter = r_pc_out;
    assign o_accumulator     = $signed(r_a_out);
    assign o_negative        = r_neg_out;
    assign o_running         = r_run_out;
    assign o_out_valid       = r_shown;
    assign o_out_address     = r_show_addr;
    assign o_out_value       = $signed(r_show_val);

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the accumulator CPU step unit. A state tracker
// mirrors memory, registers and flags, predicts the report for every command
// transfer and compares it with the reports the unit returns. A directed
// program comes first, then random program fragments, data writes and
// stray commands. The halt is exercised at the end only, since nothing but
// reset restarts the processor.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned MEM_WORDS  = 256;
    localparam logic [1:0]  ACT_UNUSED = 2'd3;
    localparam int unsigned ITEM_COUNT = 400;
    localparam int unsigned IDLE_LIMIT = 2000;
    localparam int unsigned REPORT_MAX = 10;
    localparam int unsigned DRAIN_STEP = 120;

    // Receiver stall patterns.
    localparam int unsigned RDY_ALWAYS = 0;
    localparam int unsigned RDY_COIN   = 1;
    localparam int unsigned RDY_SPARSE = 2;

    typedef struct packed {
        logic [7:0]  pc;
        logic [15:0] acc;
        logic        neg;
        logic        run;
        logic        shown;
        logic [7:0]  show_addr;
        logic [15:0] show_val;
    } t_step_report;

    class cpu_state_tracker;
        logic [15:0]  mem [256];
        logic [15:0]  reg_a;
        logic [15:0]  reg_b;
        logic [7:0]   pc;
        logic         neg;
        logic         run;
        t_step_report expected_reports [$];
        int unsigned  errors;

        function new();
            foreach (mem[i]) mem[i] = acs_pkg::RESET_WORD;
            reg_a  = '0;
            reg_b  = '0;
            pc     = '0;
            neg    = 1'b0;
            run    = 1'b1;
            errors = 0;
        endfunction

        function logic [15:0] read_word(logic [7:0] addr);
            if (addr >= MEM_WORDS) return acs_pkg::RESET_WORD;
            return mem[addr];
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void apply_command(logic [1:0] action, logic [7:0] address,
                                    logic [15:0] data);
            logic [15:0]  word;
            logic [7:0]   operand;
            logic [7:0]   next_pc;
            t_step_report r;
            r = '0;
            if (action == acs_pkg::ACT_WRITE) begin
                if (address < MEM_WORDS) mem[address] = data;
            end else if (action == acs_pkg::ACT_SET_PC) begin
                pc = address;
            end else if (action == acs_pkg::ACT_EXEC && run) begin
                word    = read_word(pc);
                operand = word[7:0];
                next_pc = pc + 8'd1;
                unique case (word[15:8])
                    acs_pkg::OP_LOAD: begin
                        reg_a = read_word(operand);
                        neg   = reg_a[15];
                        pc    = next_pc;
                    end
                    acs_pkg::OP_STORE: begin
                        if (operand < MEM_WORDS) mem[operand] = reg_a;
                        pc = next_pc;
                    end
                    acs_pkg::OP_ADD: begin
                        reg_a = reg_a + reg_b;
                        neg   = reg_a[15];
                        pc    = next_pc;
                    end
                    acs_pkg::OP_SUB: begin
                        reg_a = reg_a - reg_b;
                        neg   = reg_a[15];
                        pc    = next_pc;
                    end
                    acs_pkg::OP_COPY_B: begin
                        reg_b = reg_a;
                        pc    = next_pc;
                    end
                    acs_pkg::OP_JUMP: begin
                        pc = operand;
                    end
                    acs_pkg::OP_JUMP_N: begin
                        pc = neg ? operand : next_pc;
                    end
                    acs_pkg::OP_OUTPUT: begin
                        r.shown     = 1'b1;
                        r.show_addr = operand;
                        r.show_val  = read_word(operand);
                        pc          = next_pc;
                    end
                    default: begin
                        // halt: pc stays on the halt word
                        run = 1'b0;
                    end
                endcase
            end
            r.pc  = pc;
            r.acc = reg_a;
            r.neg = neg;
            r.run = run;
            expected_reports.push_back(r);
        endfunction

        function void check_report(t_step_report got);
            t_step_report want;
            if (expected_reports.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("ERROR: unexpected report pc=%02h acc=%04h neg=%0b run=%0b",
                             got.pc, got.acc, got.neg, got.run);
                return;
            end
            want = expected_reports.pop_front();
            if (got.pc !== want.pc || got.acc !== want.acc || got.neg !== want.neg ||
                got.run !== want.run || got.shown !== want.shown ||
                got.show_addr !== want.show_addr || got.show_val !== want.show_val) begin
                errors++;
                if (errors <= REPORT_MAX) begin
                    $display("ERROR: expected pc=%02h acc=%04h neg=%0b run=%0b out=%0b %02h %04h",
                             want.pc, want.acc, want.neg, want.run, want.shown,
                             want.show_addr, want.show_val);
                    $display("       actual   pc=%02h acc=%04h neg=%0b run=%0b out=%0b %02h %04h",
                             got.pc, got.acc, got.neg, got.run, got.shown,
                             got.show_addr, got.show_val);
                end
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_action;
    logic [7:0]         i_address;
    logic signed [15:0] i_data;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [7:0]         o_program_counter;
    logic signed [15:0] o_accumulator;
    logic               o_negative;
    logic               o_running;
    logic               o_out_valid;
    logic [7:0]         o_out_address;
    logic signed [15:0] o_out_value;

    cpu_state_tracker tracker;
    t_step_report     seen_report;
    int unsigned      burst_left;
    int unsigned      sent;
    int unsigned      ready_mode;
    int unsigned      ready_left;
    int unsigned      ready_tick;
    int unsigned      idle_cycles;

    accumulator_cpu_step_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_action          (i_action),
        .i_address         (i_address),
        .i_data            (i_data),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_program_counter (o_program_counter),
        .o_accumulator     (o_accumulator),
        .o_negative        (o_negative),
        .o_running         (o_running),
        .o_out_valid       (o_out_valid),
        .o_out_address     (o_out_address),
        .o_out_value       (o_out_value)
    );

    always #6 i_clk = ~i_clk;

    // Receiver: switch between stall patterns after runs of random length.
    always @(negedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(8, 48);
        end
        ready_left--;
        ready_tick++;
        unique case (ready_mode)
            RDY_ALWAYS: i_ready = 1'b1;
            RDY_COIN:   i_ready = 1'($urandom_range(0, 1));
            RDY_SPARSE: i_ready = (ready_tick % 4 == 0);
            default:    i_ready = 1'b1;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen_report.pc        = o_program_counter;
            seen_report.acc       = o_accumulator;
            seen_report.neg       = o_negative;
            seen_report.run       = o_running;
            seen_report.shown     = o_out_valid;
            seen_report.show_addr = o_out_address;
            seen_report.show_val  = o_out_value;
            tracker.check_report(seen_report);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [15:0] instr(logic [7:0] op, logic [7:0] operand);
        return {op, operand};
    endfunction

    function automatic logic [15:0] rand_instr();
        logic [7:0] op;
        logic [7:0] operand;
        op      = 8'($urandom_range(0, 7));
        operand = 8'($urandom_range(0, 255));
        // aim loads, stores and outputs at the data area half the time
        if ((op == acs_pkg::OP_LOAD || op == acs_pkg::OP_STORE ||
             op == acs_pkg::OP_OUTPUT) && $urandom_range(0, 1))
            operand = 8'hE0 + 8'($urandom_range(0, 31));
        return {op, operand};
    endfunction

    function automatic logic [15:0] rand_data();
        unique case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic drive_cmd(input logic [1:0] action, input logic [7:0] address,
                             input logic [15:0] data);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge i_clk);
        i_valid   = 1'b1;
        i_action  = action;
        i_address = address;
        i_data    = data;
        do begin
            @(posedge i_clk);
        end while (o_ready !== 1'b1);
        tracker.apply_command(action, address, data);
        sent++;
    endtask

    // Hold the sender until every pending report has come back.
    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    // Execute one instruction, first patching a halt word at pc so the
    // processor keeps running through the random part.
    task automatic exec_step();
        logic [15:0] fetched;
        fetched = tracker.read_word(tracker.pc);
        if (fetched[15:8] > acs_pkg::OP_OUTPUT)
            drive_cmd(acs_pkg::ACT_WRITE, tracker.pc, rand_instr());
        drive_cmd(acs_pkg::ACT_EXEC, 8'($urandom), 16'($urandom));
    endtask

    initial begin
        int unsigned pick;
        int unsigned len;
        int unsigned next_drain;
        logic [7:0]  base;
        logic [7:0]  halt_at;

        tracker   = new();
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_action  = acs_pkg::ACT_WRITE;
        i_address = '0;
        i_data    = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed program: wrap on add, both jump-if-negative outcomes,
        // store, output, jump and pc wrap from 255 to 0.
        drive_cmd(acs_pkg::ACT_WRITE, 8'h10, 16'h7FFF);
        drive_cmd(acs_pkg::ACT_WRITE, 8'h11, 16'h8000);
        drive_cmd(acs_pkg::ACT_WRITE, 8'h00, instr(acs_pkg::OP_LOAD, 8'h10));
        drive_cmd(acs_pkg::ACT_WRITE, 8'h01, instr(acs_pkg::OP_COPY_B, 8'h00));
        drive_cmd(acs_pkg::ACT_WRITE, 8'h02, instr(acs_pkg::OP_ADD, 8'h00));
        drive_cmd(acs_pkg::ACT_WRITE, 8'h03, instr(acs_pkg::OP_JUMP_N, 8'h06));
        drive_cmd(acs_pkg::ACT_WRITE, 8'h06, instr(acs_pkg::OP_SUB, 8'h00));
        drive_cmd(acs_pkg::ACT_WRITE, 8'h07, instr(acs_pkg::OP_JUMP_N, 8'h00));
        drive_cmd(acs_pkg::ACT_WRITE, 8'h08, instr(acs_pkg::OP_STORE, 8'h20));
        drive_cmd(acs_pkg::ACT_WRITE, 8'h09, instr(acs_pkg::OP_OUTPUT, 8'h20));
        drive_cmd(acs_pkg::ACT_WRITE, 8'h0A, instr(acs_pkg::OP_JUMP, 8'hFF));
        drive_cmd(acs_pkg::ACT_WRITE, 8'hFF, instr(acs_pkg::OP_LOAD, 8'h11));
        drive_cmd(ACT_UNUSED, 8'hFF, 16'hFFFF);
        drive_cmd(acs_pkg::ACT_SET_PC, 8'h00, 16'h0000);
        repeat (10) drive_cmd(acs_pkg::ACT_EXEC, 8'h00, 16'h0000);

        next_drain = sent + DRAIN_STEP;
        while (sent < ITEM_COUNT - 8) begin
            pick = $urandom_range(0, 19);
            if (pick < 12) begin
                base = 8'($urandom_range(0, 255));
                len  = $urandom_range(2, 6);
                for (int unsigned k = 0; k < len; k++)
                    drive_cmd(acs_pkg::ACT_WRITE, base + 8'(k), rand_instr());
                drive_cmd(acs_pkg::ACT_SET_PC, base, 16'($urandom));
                repeat (len + $urandom_range(0, 3)) exec_step();
            end else if (pick < 16) begin
                repeat ($urandom_range(1, 4))
                    drive_cmd(acs_pkg::ACT_WRITE,
                              $urandom_range(0, 3) ? 8'hE0 + 8'($urandom_range(0, 31))
                                                   : 8'($urandom),
                              rand_data());
            end else if (pick < 18) begin
                repeat ($urandom_range(1, 4)) exec_step();
            end else if (pick == 18) begin
                drive_cmd(acs_pkg::ACT_SET_PC, 8'($urandom), 16'($urandom));
            end else begin
                drive_cmd(ACT_UNUSED, 8'($urandom), 16'($urandom));
            end
            if (sent >= next_drain) begin
                drain();
                next_drain = sent + DRAIN_STEP;
            end
        end

        // Halt, then show that exec does nothing while writes and pc loads
        // still take effect without restarting.
        drain();
        halt_at = 8'($urandom_range(0, 255));
        drive_cmd(acs_pkg::ACT_WRITE, halt_at,
                  {($urandom_range(0, 1) ? 8'h08 : 8'($urandom_range(9, 255))),
                   8'($urandom)});
        drive_cmd(acs_pkg::ACT_SET_PC, halt_at, 16'($urandom));
        drive_cmd(acs_pkg::ACT_EXEC, 8'($urandom), 16'($urandom));
        drive_cmd(acs_pkg::ACT_EXEC, 8'($urandom), 16'($urandom));
        drive_cmd(acs_pkg::ACT_WRITE, halt_at, instr(acs_pkg::OP_LOAD, 8'h10));
        drive_cmd(acs_pkg::ACT_SET_PC, halt_at, 16'($urandom));
        drive_cmd(acs_pkg::ACT_EXEC, 8'($urandom), 16'($urandom));
        drive_cmd(ACT_UNUSED, 8'($urandom), 16'($urandom));

        drain();
        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
